>>> hw/rtl/boxd_pkg.sv
// ----------------------------------------------------------------------------
// Box downsample ASCII ramp package
// Shared widths, register indexes, reset values and the character ramp.
// ----------------------------------------------------------------------------
package boxd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_TILE_DEF  = 16;

    localparam int PIXEL_W        = 8;
    localparam int CHAR_W         = 8;
    localparam int TILE_SIZE_W    = 5;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int NUM_CHANNELS   = 3;
    localparam int AVG_SUM_W      = 10;
    localparam int LEVEL_W        = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_TILE_SIZE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [TILE_SIZE_W-1:0]    TILE_SIZE_RST    = 5'd8;
    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 12'd768;

    localparam int RAMP_LEN   = 11;
    localparam int PIXEL_MAX  = 255;
    localparam int LEVEL_STEP = PIXEL_MAX / RAMP_LEN;
    localparam int GREY_DIV   = NUM_CHANNELS * LEVEL_STEP;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

    localparam logic [CHAR_W-1:0] RAMP_CHARS [0:RAMP_LEN-1] =
        '{"Q", "d", "o", "g", "c", "*", ";", ":", "-", ".", " "};

    // The sum of the three channel averages divided by three and then by the
    // level step equals one division by their product; the level is capped.
    function automatic logic [LEVEL_W-1:0] grey_level(input logic [AVG_SUM_W-1:0] s);
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int k = 1; k < RAMP_LEN; k++)
        begin
            if (int'(s) >= k * GREY_DIV)
            begin
                lvl = LEVEL_W'(k);
            end
        end
        return lvl;
    endfunction

endpackage

>>> hw/rtl/box_downsample_ascii_ramp.sv
// ----------------------------------------------------------------------------
// Box downsample ASCII ramp
// Averages square tiles of an RGB raster stream and emits one ramp
// character per tile, with a newline after the last tile of each tile row.
// ----------------------------------------------------------------------------
// A pixel that does not close a tile keeps pixel_ready high: its tile
// column entry is read from the sum memory in the beat cycle and written
// back in the next, and a following pixel to the same entry is forwarded
// around the memory. A pixel that closes a tile holds pixel_ready low
// through the write-back, eight divider steps that turn the channel sums
// into averages, the character lookup and the character beat, and a
// newline beat as well when its tile ends a tile row; a stalled character
// side adds to this. The sum memory needs no clearing after reset, since
// the first pixel of each tile writes its entry. Pixels outside whole
// tiles are taken and dropped.
module box_downsample_ascii_ramp #(
    parameter int MAX_WIDTH = boxd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_TILE  = boxd_pkg::MAX_TILE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [boxd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [boxd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [boxd_pkg::PIXEL_W-1:0]      red,
    input  logic [boxd_pkg::PIXEL_W-1:0]      green,
    input  logic [boxd_pkg::PIXEL_W-1:0]      blue,
    output logic                              char_valid,
    input  logic                              char_ready,
    output logic [boxd_pkg::CHAR_W-1:0]       char_code,
    output logic                              last
);

    localparam int TW     = boxd_pkg::TILE_SIZE_W;
    localparam int WW     = boxd_pkg::IMAGE_WIDTH_W;
    localparam int HW     = boxd_pkg::IMAGE_HEIGHT_W;
    localparam int PW     = boxd_pkg::PIXEL_W;
    localparam int NCH    = boxd_pkg::NUM_CHANNELS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int TIN_W  = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
    localparam int SUM_W  = PW + $clog2(MAX_TILE * MAX_TILE);
    localparam int XW     = ((COL_W > WW) ? COL_W : WW) + 2;
    localparam int YW     = HW + 2;
    localparam int CW     = ((TIN_W > TW) ? TIN_W : TW) + 1;
    localparam int AREA_W = 2 * TW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_CHAR = 3'd3;
    localparam logic [2:0] ST_NL   = 3'd4;

    logic [TW-1:0] tile_size_reg;
    logic [WW-1:0] image_width_reg;
    logic [HW-1:0] image_height_reg;
    logic          cfg_hit;

    logic [TW-1:0] t_eff;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [TIN_W-1:0] col_in_tile_reg, col_in_tile_next;
    logic [COL_W-1:0] tile_column_reg, tile_column_next;
    logic [TIN_W-1:0] row_in_tile_reg, row_in_tile_next;
    logic [HW-1:0]    row_count_reg, row_count_next;

    logic [XW-1:0] tile_end;
    logic          col_ok;
    logic          row_ok;
    logic          in_region;
    logic          last_tile;
    logic          col_tile_end;
    logic          row_tile_end;
    logic          row_end;
    logic          frame_end;

    logic [2:0] state_reg, state_next;
    logic       pixel_accept;
    logic       take_item;

    logic [PW-1:0]    px_reg [NCH];
    logic             first_reg;
    logic             done_reg;
    logic             nl_reg;
    logic [COL_W-1:0] addr_reg;

    logic [NCH*SUM_W-1:0] rd_data;
    logic [NCH*SUM_W-1:0] new_sums;
    logic                 wr_en;

    logic                            div_start;
    logic                            div_done;
    logic [AREA_W-1:0]               area;
    logic [boxd_pkg::AVG_SUM_W-1:0]  avg_sum;
    logic [boxd_pkg::CHAR_W-1:0]     ramp_char_reg;

    logic                        out_free;
    logic                        char_valid_reg;
    logic [boxd_pkg::CHAR_W-1:0] char_code_reg;
    logic                        last_reg;

    // Configuration registers.
    always_comb
    begin
        unique case (cfg_index)
            boxd_pkg::REG_TILE_SIZE,
            boxd_pkg::REG_IMAGE_WIDTH,
            boxd_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg    <= boxd_pkg::TILE_SIZE_RST;
            image_width_reg  <= boxd_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= boxd_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == boxd_pkg::REG_TILE_SIZE)
            begin
                tile_size_reg <= cfg_data[TW-1:0];
            end
            if (cfg_index == boxd_pkg::REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data[WW-1:0];
            end
            if (cfg_index == boxd_pkg::REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data[HW-1:0];
            end
        end
    end

    always_comb
    begin
        if (tile_size_reg == '0)
        begin
            t_eff = TW'(1);
        end
        else if (int'(tile_size_reg) > MAX_TILE)
        begin
            t_eff = TW'(MAX_TILE);
        end
        else
        begin
            t_eff = tile_size_reg;
        end

        if (image_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = image_width_reg;
        end

        h_eff = (image_height_reg == '0) ? HW'(1) : image_height_reg;
    end

    // A pixel lies in a whole tile when the tile it belongs to ends inside
    // the row and its tile row ends inside the frame.
    assign tile_end  = XW'(col_count_reg) - XW'(col_in_tile_reg) + XW'(t_eff);
    assign col_ok    = tile_end <= XW'(w_eff);
    assign last_tile = (tile_end + XW'(t_eff)) > XW'(w_eff);
    assign row_ok    = (YW'(row_count_reg) - YW'(row_in_tile_reg) + YW'(t_eff))
                       <= YW'(h_eff);
    assign in_region    = col_ok && row_ok;
    assign col_tile_end = (CW'(col_in_tile_reg) + CW'(1)) >= CW'(t_eff);
    assign row_tile_end = (CW'(row_in_tile_reg) + CW'(1)) >= CW'(t_eff);
    assign row_end      = (XW'(col_count_reg) + XW'(1)) >= XW'(w_eff);
    assign frame_end    = (YW'(row_count_reg) + YW'(1)) >= YW'(h_eff);

    assign pixel_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && !done_reg);
    assign pixel_accept = pixel_valid && pixel_ready;
    assign take_item    = pixel_accept && in_region;

    always_comb
    begin
        col_count_next   = col_count_reg;
        col_in_tile_next = col_in_tile_reg;
        tile_column_next = tile_column_reg;
        row_in_tile_next = row_in_tile_reg;
        row_count_next   = row_count_reg;

        if (in_region)
        begin
            if (col_tile_end)
            begin
                col_in_tile_next = '0;
                tile_column_next = tile_column_reg + COL_W'(1);
            end
            else
            begin
                col_in_tile_next = col_in_tile_reg + TIN_W'(1);
            end
        end

        if (row_end)
        begin
            col_count_next   = '0;
            col_in_tile_next = '0;
            tile_column_next = '0;
            if (row_ok)
            begin
                row_in_tile_next = row_tile_end ? '0 : row_in_tile_reg + TIN_W'(1);
            end
            if (frame_end)
            begin
                row_count_next   = '0;
                row_in_tile_next = '0;
            end
            else
            begin
                row_count_next = row_count_reg + HW'(1);
            end
        end
        else
        begin
            col_count_next = col_count_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            col_in_tile_reg <= '0;
            tile_column_reg <= '0;
            row_in_tile_reg <= '0;
            row_count_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            col_count_reg   <= '0;
            col_in_tile_reg <= '0;
            tile_column_reg <= '0;
            row_in_tile_reg <= '0;
            row_count_reg   <= '0;
        end
        else if (pixel_accept)
        begin
            col_count_reg   <= col_count_next;
            col_in_tile_reg <= col_in_tile_next;
            tile_column_reg <= tile_column_next;
            row_in_tile_reg <= row_in_tile_next;
            row_count_reg   <= row_count_next;
        end
    end

    // Item held through the read-modify-write and the result beats.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            nl_reg    <= 1'b0;
        end
        else if (take_item)
        begin
            first_reg <= (row_in_tile_reg == '0) && (col_in_tile_reg == '0);
            done_reg  <= row_tile_end && col_tile_end;
            nl_reg    <= last_tile;
        end
        else if (state_reg == ST_UPD)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            px_reg[0] <= red;
            px_reg[1] <= green;
            px_reg[2] <= blue;
            addr_reg  <= tile_column_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (first_reg)
            begin
                new_sums[c*SUM_W +: SUM_W] = SUM_W'(px_reg[c]);
            end
            else
            begin
                new_sums[c*SUM_W +: SUM_W] = rd_data[c*SUM_W +: SUM_W] + SUM_W'(px_reg[c]);
            end
        end
    end

    assign wr_en = (state_reg == ST_UPD);

    boxd_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (NCH * SUM_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (take_item),
        .rd_addr (tile_column_reg),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (new_sums),
        .rd_data (rd_data)
    );

    assign div_start = (state_reg == ST_UPD) && done_reg;
    assign area      = AREA_W'(t_eff) * AREA_W'(t_eff);

    boxd_div #(
        .MAX_TILE (MAX_TILE)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .area    (area),
        .sums    (new_sums),
        .done    (div_done),
        .avg_sum (avg_sum)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            ramp_char_reg <= boxd_pkg::RAMP_CHARS[boxd_pkg::grey_level(avg_sum)];
        end
    end

    assign out_free = !char_valid_reg || char_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (done_reg)
                begin
                    state_next = ST_DIV;
                end
                else if (!take_item)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    state_next = nl_reg ? ST_NL : ST_IDLE;
                end
            end
            ST_NL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (((state_reg == ST_CHAR) || (state_reg == ST_NL)) && out_free)
        begin
            char_valid_reg <= 1'b1;
        end
        else if (char_ready)
        begin
            char_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CHAR) && out_free)
        begin
            char_code_reg <= ramp_char_reg;
            last_reg      <= !nl_reg;
        end
        else if ((state_reg == ST_NL) && out_free)
        begin
            char_code_reg <= boxd_pkg::NEWLINE;
            last_reg      <= 1'b1;
        end
    end

    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign last       = last_reg;

    a_newline_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !last) |-> (char_code != boxd_pkg::NEWLINE))
        else $error("newline beat without last");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_no_accept_on_tile_close: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPD) && pixel_accept) |-> !done_reg)
        else $error("pixel taken while a closing tile is written back");

endmodule

>>> hw/rtl/boxd_mem.sv
// ----------------------------------------------------------------------------
// Tile sum memory
// One entry per tile column with a registered read port and a write port.
// A read of the entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module boxd_mem #(
    parameter int DEPTH  = boxd_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/boxd_div.sv
// ----------------------------------------------------------------------------
// Tile average divider
// Three restoring divider lanes that divide the channel sums by the tile
// area, one quotient bit per cycle, and add the three averages.
// ----------------------------------------------------------------------------
module boxd_div #(
    parameter int MAX_TILE = boxd_pkg::MAX_TILE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [2*boxd_pkg::TILE_SIZE_W-1:0]    area,
    input  logic [boxd_pkg::NUM_CHANNELS*(boxd_pkg::PIXEL_W
                  + $clog2(MAX_TILE*MAX_TILE))-1:0] sums,
    output logic                                  done,
    output logic [boxd_pkg::AVG_SUM_W-1:0]        avg_sum
);

    localparam int SUM_W  = boxd_pkg::PIXEL_W + $clog2(MAX_TILE * MAX_TILE);
    localparam int AREA_W = 2 * boxd_pkg::TILE_SIZE_W;
    localparam int QW     = boxd_pkg::PIXEL_W;
    localparam int DW     = (SUM_W > AREA_W + QW) ? SUM_W : AREA_W + QW;
    localparam int STEP_W = $clog2(QW);
    localparam int NCH    = boxd_pkg::NUM_CHANNELS;

    logic [DW-1:0]     rem_reg  [NCH];
    logic [DW-1:0]     rem_next [NCH];
    logic [QW-1:0]     quot_reg  [NCH];
    logic [QW-1:0]     quot_next [NCH];
    logic [DW-1:0]     dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (rem_reg[c] >= dvs_reg)
            begin
                rem_next[c]  = rem_reg[c] - dvs_reg;
                quot_next[c] = {quot_reg[c][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[c]  = rem_reg[c];
                quot_next[c] = {quot_reg[c][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (step_reg == '0))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                rem_reg[c]  <= DW'(sums[c*SUM_W +: SUM_W]);
                quot_reg[c] <= '0;
            end
            dvs_reg  <= DW'(area) << (QW - 1);
            step_reg <= STEP_W'(QW - 1);
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                rem_reg[c]  <= rem_next[c];
                quot_reg[c] <= quot_next[c];
            end
            dvs_reg  <= dvs_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done    = done_reg;
    assign avg_sum = boxd_pkg::AVG_SUM_W'(quot_reg[0]) + boxd_pkg::AVG_SUM_W'(quot_reg[1])
                   + boxd_pkg::AVG_SUM_W'(quot_reg[2]);

endmodule
